[rtl/fst_pkg.sv]
package fst_pkg;

    localparam int unsigned REQ_W = 2;
    localparam int unsigned ROLE_W = 3;
    localparam int unsigned PRIO_W = 16;
    localparam int unsigned POS_W = 32;
    localparam int unsigned QUAT_W = 16;
    localparam int unsigned SPACING_W = 16;
    localparam int unsigned BEST_W = 4;
    localparam int unsigned PADDR_W = 1;
    localparam int unsigned MUL_A_W = 48;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned WIDE_W = 66;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd256;
    localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = -16'sd256;
    localparam logic [PADDR_W-1:0] ADDR_SPACING = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_POS    = 2'd2,
        REQ_ROLE   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SCALE,
        ST_CROSS1,
        ST_ROT,
        ST_CROSS2,
        ST_SCAN1,
        ST_SCAN2,
        ST_DONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]              req_type;
        logic signed [POS_W-1:0]       vec_x;
        logic signed [POS_W-1:0]       vec_y;
        logic signed [POS_W-1:0]       vec_z;
        logic signed [QUAT_W-1:0]      quat_w;
        logic signed [QUAT_W-1:0]      quat_x;
        logic signed [QUAT_W-1:0]      quat_y;
        logic signed [QUAT_W-1:0]      quat_z;
        logic [ROLE_W-1:0]             role;
        logic signed [PRIO_W-1:0]      priority_req;
        logic [7:0]                    slot_index;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [BEST_W-1:0]       best_slot;
        logic                    slot_found;
        logic                    status;
    } t_out;

endpackage

[rtl/fst_if.sv]
interface fst_in_if;
    import fst_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fst_out_if;
    import fst_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/fst_ram.sv]
module fst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/fst_mul.sv]
module fst_mul (
    input  logic                                  i_clk,
    input  logic signed [fst_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [fst_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [fst_pkg::WIDE_W-1:0]     o_p
);
    import fst_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= WIDE_W'(i_a * i_b);
    end
endmodule

[rtl/formation_slot_table.sv]
// Append and clear go through ST_DONE, where the result is registered, to ST_OUT.
// A world position query issues 18 products through one shared multiplier in the scale,
// cross1, rot and cross2 phases, or goes to ST_DONE when the index is out of range.
// A role query picks the highest-priority slot of the role, scanning all slots again when
// none of the role qualifies. The next item is accepted once the result is taken.
// Synchronous active-low reset clears the slot count and control state and sets spacing to 256.
module formation_slot_table #(
    parameter int unsigned MAX_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fst_in_if.sink                        in_ch,
    fst_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fst_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fst_pkg::*;

    localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned SW = 50;
    localparam int unsigned TW = 43;
    localparam int unsigned STORE_W = 3 * POS_W + ROLE_W + PRIO_W;

    t_state r_state, n_state;
    t_in r_in;
    t_out r_out, n_out;
    logic [CW-1:0] r_count;
    logic [SPACING_W-1:0] r_spacing;
    logic [4:0] r_step;
    logic [CW-1:0] r_scan;
    logic signed [SW-1:0] r_s [3];
    logic signed [TW-1:0] r_t [3];
    logic signed [WIDE_W-1:0] r_acc;
    logic signed [POS_W-1:0] r_r [3];
    logic signed [PRIO_W-1:0] r_best_p;
    logic [BEST_W-1:0] r_best;
    logic r_found, r_pass2, r_rd_valid;
    logic [CW-1:0] r_rd_idx;

    logic ram_we;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [STORE_W-1:0] ram_wdata, ram_rdata;
    logic signed [POS_W-1:0] st_x, st_y, st_z;
    logic [ROLE_W-1:0] st_role;
    logic signed [PRIO_W-1:0] st_prio;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [WIDE_W-1:0] mul_p;
    logic in_fire, out_fire;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (r_state == ST_IDLE);
    assign out_ch.valid = (r_state == ST_OUT);
    assign out_ch.data = r_out;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SPACING) ? {16'd0, r_spacing} : 32'd0;

    assign ram_we = in_fire && (in_ch.data.req_type == REQ_APPEND) && (r_count < CW'(MAX_SLOTS));
    assign ram_waddr = AW'(r_count);
    assign ram_wdata = {in_ch.data.vec_x, in_ch.data.vec_y, in_ch.data.vec_z,
                        in_ch.data.role, in_ch.data.priority_req};
    assign ram_raddr = (r_state == ST_READ || r_state == ST_SCALE) ? AW'(r_in.slot_index)
                                                                   : AW'(r_scan);
    assign {st_x, st_y, st_z, st_role, st_prio} = ram_rdata;

    fst_ram #(.WIDTH(STORE_W), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    fst_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    // Product schedule. Scale: steps 0..2 issue offset*spacing.
    // Cross1: steps 0..5 issue q x s terms, Rot: 0..2 qw*t, Cross2: 0..5 q x t terms.
    logic signed [QUAT_W-1:0] qa;
    logic [1:0] vi;
    logic neg;
    always_comb begin
        qa = r_in.quat_x;
        vi = 2'd0;
        neg = 1'b0;
        case (r_step[3:0])
            4'd0: begin qa = r_in.quat_y; vi = 2'd2; end
            4'd1: begin qa = r_in.quat_z; vi = 2'd1; neg = 1'b1; end
            4'd2: begin qa = r_in.quat_z; vi = 2'd0; end
            4'd3: begin qa = r_in.quat_x; vi = 2'd2; neg = 1'b1; end
            4'd4: begin qa = r_in.quat_x; vi = 2'd1; end
            4'd5: begin qa = r_in.quat_y; vi = 2'd0; neg = 1'b1; end
            default: begin qa = r_in.quat_x; vi = 2'd0; end
        endcase
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SCALE: begin
                mul_a = MUL_A_W'(r_step[1:0] == 2'd0 ? st_x : (r_step[1:0] == 2'd1 ? st_y : st_z));
                mul_b = MUL_B_W'({1'b0, r_spacing});
            end
            ST_CROSS1: begin
                mul_a = MUL_A_W'(r_s[vi]);
                mul_b = neg ? -MUL_B_W'(qa) : MUL_B_W'(qa);
            end
            ST_ROT: begin
                mul_a = MUL_A_W'(r_t[r_step[1:0]]);
                mul_b = MUL_B_W'(r_in.quat_w);
            end
            ST_CROSS2: begin
                mul_a = MUL_A_W'(r_t[vi]);
                mul_b = neg ? -MUL_B_W'(qa) : MUL_B_W'(qa);
            end
            default: ;
        endcase
    end

    // The multiplier output is registered, so each product is captured at the following step; r_step counts to last.
    logic [4:0] last;
    always_comb begin
        case (r_state)
            ST_SCALE, ST_ROT: last = 5'd3;
            default:          last = 5'd6;
        endcase
    end
    logic [1:0] ri;
    assign ri = (r_state == ST_SCALE || r_state == ST_ROT) ? 2'(r_step - 5'd1)
                                                           : 2'((r_step - 5'd1) >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_ch.data.req_type)
                        REQ_POS:  n_state = ST_READ;
                        REQ_ROLE: n_state = ST_SCAN1;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                n_state = (CW'(r_in.slot_index) < r_count && r_in.slot_index < 8'(MAX_SLOTS))
                          ? ST_SCALE : ST_DONE;
            end
            ST_SCALE:  if (r_step == last) n_state = ST_CROSS1;
            ST_CROSS1: if (r_step == last) n_state = ST_ROT;
            ST_ROT:    if (r_step == last) n_state = ST_CROSS2;
            ST_CROSS2: if (r_step == last) n_state = ST_DONE;
            ST_SCAN1, ST_SCAN2: begin
                if (r_scan >= r_count && !r_rd_valid) begin
                    n_state = (r_state == ST_SCAN1 && !r_found) ? ST_SCAN2 : ST_DONE;
                end
            end
            ST_DONE:   n_state = ST_OUT;
            ST_OUT:    if (out_fire) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out = '0;
        case (r_in.req_type)
            REQ_APPEND: n_out.status = r_pass2;
            REQ_POS: begin
                n_out.pos_x = r_in.vec_x + r_r[0];
                n_out.pos_y = r_in.vec_y + r_r[1];
                n_out.pos_z = r_in.vec_z + r_r[2];
            end
            REQ_ROLE: begin
                n_out.best_slot = r_best;
                n_out.slot_found = r_found;
            end
            default: ;
        endcase
    end

    logic match;
    assign match = (r_state == ST_SCAN2 || st_role == r_in.role) && (st_prio > r_best_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_spacing <= SPACING_RESET;
            r_rd_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && paddr == ADDR_SPACING) begin
                r_spacing <= pwdata[SPACING_W-1:0];
            end
            if (in_fire && in_ch.data.req_type == REQ_CLEAR) r_count <= '0;
            if (ram_we) r_count <= r_count + CW'(1);
            r_rd_valid <= (r_state == ST_SCAN1 || r_state == ST_SCAN2) && r_scan < r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= in_ch.data;
            r_pass2 <= (in_ch.data.req_type == REQ_APPEND) && (r_count >= CW'(MAX_SLOTS));
            r_scan <= '0;
            r_best_p <= PRIO_FLOOR;
            r_best <= '0;
            r_found <= 1'b0;
            for (int k = 0; k < 3; k++) r_r[k] <= '0;
        end
        if (r_state != n_state) begin
            r_step <= '0;
            r_acc <= '0;
            if (r_state == ST_SCAN1) begin
                r_scan <= '0;
            end
        end else if (r_state == ST_SCALE || r_state == ST_CROSS1 ||
                     r_state == ST_ROT || r_state == ST_CROSS2) begin
            r_step <= r_step + 5'd1;
        end
        if (r_step != 5'd0) begin
            case (r_state)
                ST_SCALE: r_s[ri] <= SW'(mul_p >>> 8);
                ST_ROT:   r_r[ri] <= r_r[ri] + POS_W'(mul_p >>> 15);
                ST_CROSS1, ST_CROSS2: begin
                    if (r_step[0]) begin
                        r_acc <= mul_p;
                    end else if (r_state == ST_CROSS1) begin
                        r_t[ri] <= TW'((r_acc + mul_p) >>> 14);
                    end else begin
                        r_r[ri] <= r_r[ri] + POS_W'((r_acc + mul_p) >>> 15);
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_CROSS1 && r_step == 5'd0) begin
            for (int k = 0; k < 3; k++) r_r[k] <= POS_W'(r_s[k]);
        end
        if ((r_state == ST_SCAN1 || r_state == ST_SCAN2) && r_state == n_state) begin
            if (r_scan < r_count) r_scan <= r_scan + CW'(1);
            r_rd_idx <= r_scan;
            if (r_rd_valid && match) begin
                r_best_p <= st_prio;
                r_best <= BEST_W'(r_rd_idx);
                r_found <= 1'b1;
            end
        end else if (r_state == ST_SCAN1) begin
            if (r_rd_valid && match) begin
                r_best_p <= st_prio;
                r_best <= BEST_W'(r_rd_idx);
                r_found <= 1'b1;
            end
        end
        if (r_state == ST_DONE) r_out <= n_out;
    end
endmodule

[rtl/fst_checker.sv]
module fst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic slot_found,
    input logic [3:0] best_slot
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !slot_found |-> best_slot == 4'd0) else $error("best slot nonzero");
endmodule

bind formation_slot_table fst_checker u_fst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .slot_found(out_ch.data.slot_found), .best_slot(out_ch.data.best_slot)
);
